// ===== rtl/core/nmi_pkg.sv =====
package nmi_pkg;

    localparam int CNT_W          = 17;
    localparam int LBL_IN_W       = 6;
    localparam int LOG_W          = 22;
    localparam int ACC_W          = 48;
    localparam int MAX_LABELS_DEF = 64;
    localparam int MAX_POINTS_DEF = 65536;

    localparam logic [CNT_W-1:0] CNT_MAX      = 17'h1FFFF;
    localparam logic [CNT_W-1:0] TOTAL_RESET  = 17'h10000;
    localparam logic [CNT_W-1:0] NMI_ONE      = 17'h10000;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_OVER = 2'd2;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_UPD, S_CHK, S_LNW, S_RD, S_RDW, S_PICK,
        S_LOGW, S_ACC, S_PN, S_ND, S_DV0, S_DIV, S_FIN, S_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] x;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } log_rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
    endfunction

endpackage

// ===== rtl/core/nmi_ram.sv =====
module nmi_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/nmi_log.sv =====
module nmi_log (
    input  logic              aclk,
    input  logic              aresetn,
    input  nmi_pkg::log_req_t req,
    output nmi_pkg::log_rsp_t rsp
);

    import nmi_pkg::*;

    logic [31:0]      y_reg, y_next;
    logic [15:0]      frac_reg, frac_next;
    logic [4:0]       e_reg, e_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LOG_W-1:0] val_reg, val_next;
    logic [4:0]       e_in;
    logic [63:0]      sq;
    logic [32:0]      t;

    always_comb begin
        e_in = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (req.x[i]) begin
                e_in = 5'(i);
            end
        end
    end

    assign sq = 64'(y_reg) * 64'(y_reg);
    assign t  = sq[63:31];

    always_comb begin
        y_next    = y_reg;
        frac_next = frac_reg;
        e_next    = e_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        val_next  = val_reg;
        if (req.start) begin
            y_next    = 32'(req.x) << (5'd31 - e_in);
            e_next    = e_in;
            frac_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (t[32]) begin
                y_next    = t[32:1];
                frac_next = {frac_reg[14:0], 1'b1};
            end else begin
                y_next    = t[31:0];
                frac_next = {frac_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                val_next  = {1'b0, e_reg, frac_next};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        y_reg    <= y_next;
        frac_reg <= frac_next;
        e_reg    <= e_next;
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

endmodule

// ===== rtl/core/normalized_mutual_information_unit.sv =====
// channel   direction  fields                                   handshake
// s_        in         s_label_a[5:0] s_label_b[5:0] s_last_point  s_valid/s_ready
// m_        out        m_nmi_value[16:0] m_status[1:0]           m_valid/m_ready
// cfg_      in         cfg_wdata[16:0] (total_points)            cfg_we
//
// a point: histogram read in S_IDLE, then write back of the three counts in S_UPD
// after the last point and a passing count check: log2 of the total, then per joint
// entry a read and, for each nonzero count (joint, and the marginals for the first
// MAX_LABELS), the log unit and one accumulate; then numerator, denominator and,
// when needed, a restoring divide; after reset and after every result a clearing pass
// over all MAX_LABELS*MAX_LABELS joint entries runs before the next point is taken
// a waiting result holds the block before the clearing pass until it is taken
module normalized_mutual_information_unit #(
    parameter int MAX_LABELS = nmi_pkg::MAX_LABELS_DEF,
    parameter int MAX_POINTS = nmi_pkg::MAX_POINTS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [nmi_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nmi_pkg::LBL_IN_W-1:0] s_label_a,
    input  logic [nmi_pkg::LBL_IN_W-1:0] s_label_b,
    input  logic                       s_last_point,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [nmi_pkg::CNT_W-1:0]  m_nmi_value,
    output logic [1:0]                 m_status
);

    import nmi_pkg::*;

    localparam int LW  = $clog2(MAX_LABELS);
    localparam int JD  = MAX_LABELS * MAX_LABELS;
    localparam int JAW = $clog2(JD);

    function automatic logic [LW-1:0] clamp_lbl(logic [LBL_IN_W-1:0] l);
        if (32'(l) >= 32'(MAX_LABELS)) begin
            return LW'(MAX_LABELS - 1);
        end
        return LW'(l);
    endfunction

    state_t state_reg, state_next;

    logic [JAW-1:0]          k_reg, k_next;
    logic [1:0]              sel_reg, sel_next;
    logic [LW-1:0]           la_reg, la_next, lb_reg, lb_next;
    logic                    last_reg, last_next;
    logic [CNT_W-1:0]        ps_reg, ps_next;
    logic [CNT_W-1:0]        total_reg, total_next;
    logic [LOG_W-1:0]        ln_reg, ln_next;
    logic [CNT_W-1:0]        vj_reg, vj_next, va_reg, va_next, vb_reg, vb_next;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] acc_next [3];
    logic signed [ACC_W-1:0] num_reg, num_next, den_reg, den_next;
    logic [ACC_W:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]        q_reg, q_next;
    logic [4:0]              dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]        res_val_reg, res_val_next;
    logic [1:0]              res_st_reg, res_st_next;
    logic                    m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]        m_val_reg, m_val_next;
    logic [1:0]              m_st_reg, m_st_next;

    logic             a_we, b_we, j_we;
    logic [LW-1:0]    a_waddr, b_waddr, a_raddr, b_raddr;
    logic [JAW-1:0]   j_waddr, j_raddr;
    logic [CNT_W-1:0] a_wdata, b_wdata, j_wdata, a_rdata, b_rdata, j_rdata;

    log_req_t lreq;
    log_rsp_t lrsp;

    logic             accept;
    logic             k_low;
    logic [CNT_W-1:0] cur;
    logic             bad;
    logic [ACC_W:0]   r2;

    nmi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LABELS)) u_ram_a (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    nmi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LABELS)) u_ram_b (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    nmi_ram #(.WIDTH(CNT_W), .DEPTH(JD)) u_ram_j (
        .aclk(aclk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
        .raddr(j_raddr), .rdata(j_rdata)
    );

    nmi_log u_log (
        .aclk(aclk), .aresetn(aresetn), .req(lreq), .rsp(lrsp)
    );

    assign accept = s_valid && s_ready;
    assign k_low  = 32'(k_reg) < 32'(MAX_LABELS);
    assign bad    = (ps_reg > total_reg) || (32'(ps_reg) > 32'(MAX_POINTS))
                 || (ps_reg >= CNT_MAX);
    assign r2     = {rem_reg[ACC_W-1:0], 1'b0};

    always_comb begin
        case (sel_reg)
            2'd0:    cur = vj_reg;
            2'd1:    cur = va_reg;
            default: cur = vb_reg;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:  if (k_reg == JAW'(JD - 1)) state_next = S_IDLE;
            S_IDLE: if (accept) state_next = S_UPD;
            S_UPD:  state_next = last_reg ? S_CHK : S_IDLE;
            S_CHK:  state_next = bad ? S_OUT : S_LNW;
            S_LNW:  if (lrsp.done) state_next = S_RD;
            S_RD:   state_next = S_RDW;
            S_RDW:  state_next = S_PICK;
            S_PICK: begin
                if (sel_reg == 2'd3 || (sel_reg != 2'd0 && !k_low)) begin
                    state_next = (k_reg == JAW'(JD - 1)) ? S_PN : S_RD;
                end else if (cur != '0) begin
                    state_next = S_LOGW;
                end
            end
            S_LOGW: if (lrsp.done) state_next = S_ACC;
            S_ACC:  state_next = S_PICK;
            S_PN:   state_next = S_ND;
            S_ND:   state_next = S_DV0;
            S_DV0: begin
                if (den_reg <= 0 || num_reg <= 0 || num_reg >= den_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV:  if (dcnt_reg == 5'd16) state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (!m_valid_reg || m_ready) state_next = S_CLR;
            default: state_next = S_CLR;
        endcase
    end

    // datapath and outputs
    always_comb begin
        k_next       = k_reg;
        sel_next     = sel_reg;
        la_next      = la_reg;
        lb_next      = lb_reg;
        last_next    = last_reg;
        ps_next      = ps_reg;
        total_next   = cfg_we ? cfg_wdata : total_reg;
        ln_next      = ln_reg;
        vj_next      = vj_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        dcnt_next    = dcnt_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_val_next   = m_val_reg;
        m_st_next    = m_st_reg;
        s_ready      = 1'b0;
        lreq.start   = 1'b0;
        lreq.x       = cur;
        a_we = 1'b0; b_we = 1'b0; j_we = 1'b0;
        a_waddr = la_reg; b_waddr = lb_reg;
        j_waddr = JAW'(int'(la_reg) * MAX_LABELS + int'(lb_reg));
        a_wdata = sat_inc(a_rdata);
        b_wdata = sat_inc(b_rdata);
        j_wdata = sat_inc(j_rdata);
        a_raddr = k_reg[LW-1:0];
        b_raddr = k_reg[LW-1:0];
        j_raddr = k_reg;
        case (state_reg)
            S_CLR: begin
                j_we = 1'b1; j_waddr = k_reg; j_wdata = '0;
                a_we = k_low; a_waddr = k_reg[LW-1:0]; a_wdata = '0;
                b_we = k_low; b_waddr = k_reg[LW-1:0]; b_wdata = '0;
                k_next  = k_reg + 1'b1;
                ps_next = '0;
            end
            S_IDLE: begin
                s_ready   = 1'b1;
                la_next   = clamp_lbl(s_label_a);
                lb_next   = clamp_lbl(s_label_b);
                a_raddr   = la_next;
                b_raddr   = lb_next;
                j_raddr   = JAW'(int'(la_next) * MAX_LABELS + int'(lb_next));
                if (accept) begin
                    last_next = s_last_point;
                    ps_next   = sat_inc(ps_reg);
                end
            end
            S_UPD: begin
                a_we = 1'b1; b_we = 1'b1; j_we = 1'b1;
            end
            S_CHK: begin
                for (int i = 0; i < 3; i++) acc_next[i] = '0;
                if (bad) begin
                    res_val_next = '0;
                    res_st_next  = STAT_OVER;
                end else begin
                    lreq.start = 1'b1;
                    lreq.x     = total_reg;
                end
            end
            S_LNW: begin
                ln_next = lrsp.value;
                k_next  = '0;
            end
            S_RDW: begin
                vj_next  = j_rdata;
                va_next  = a_rdata;
                vb_next  = b_rdata;
                sel_next = '0;
            end
            S_PICK: begin
                if (sel_reg == 2'd3 || (sel_reg != 2'd0 && !k_low)) begin
                    k_next = k_reg + 1'b1;
                end else if (cur == '0) begin
                    sel_next = sel_reg + 1'b1;
                end else begin
                    lreq.start = 1'b1;
                end
            end
            S_LOGW: prod_next = ACC_W'(cur) * ACC_W'(lrsp.value);
            S_ACC: begin
                acc_next[sel_reg] = acc_reg[sel_reg] + prod_reg;
                sel_next = sel_reg + 1'b1;
            end
            S_PN:   prod_next = ACC_W'(ps_reg) * ACC_W'(ln_reg);
            S_ND: begin
                num_next = acc_reg[0] - acc_reg[1] - acc_reg[2] + prod_reg;
                den_next = (prod_reg <<< 1) - acc_reg[1] - acc_reg[2];
            end
            S_DV0: begin
                res_st_next  = STAT_OK;
                res_val_next = '0;
                if (den_reg <= 0) begin
                    res_st_next = STAT_ZERO;
                end else if (num_reg >= den_reg) begin
                    res_val_next = NMI_ONE;
                end
                rem_next  = (ACC_W + 1)'(num_reg);
                q_next    = '0;
                dcnt_next = '0;
            end
            S_DIV: begin
                if (r2 >= (ACC_W + 1)'(den_reg)) begin
                    rem_next = r2 - (ACC_W + 1)'(den_reg);
                    q_next   = {q_reg[CNT_W-2:0], 1'b1};
                end else begin
                    rem_next = r2;
                    q_next   = {q_reg[CNT_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
            end
            S_FIN: begin
                res_val_next = (q_reg > NMI_ONE) ? NMI_ONE : q_reg;
                res_st_next  = STAT_OK;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_st_next    = res_st_reg;
                    k_next       = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            k_reg       <= '0;
            ps_reg      <= '0;
            total_reg   <= TOTAL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            ps_reg      <= ps_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        sel_reg     <= sel_next;
        la_reg      <= la_next;
        lb_reg      <= lb_next;
        last_reg    <= last_next;
        ln_reg      <= ln_next;
        vj_reg      <= vj_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        dcnt_reg    <= dcnt_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        m_val_reg   <= m_val_next;
        m_st_reg    <= m_st_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_nmi_value = m_val_reg;
    assign m_status    = m_st_reg;

    a_div_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> den_reg > 0)
        else $error("divide running with non-positive denominator");

    a_upd_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_UPD)
        else $error("histogram write back did not follow accepted transaction");

    a_log_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        lrsp.done |-> (state_reg == S_LNW || state_reg == S_LOGW))
        else $error("log result arrived while not waited for");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && state_next == S_CLR |=> m_valid_reg)
        else $error("result not presented");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nmi_pkg::*;

    localparam int LABELS     = 64;
    localparam int IDLE_LIMIT = 200000;
    localparam int SETTLE     = 5000;
    localparam int LONG_HOLD  = 40000;

    typedef struct {
        logic [CNT_W-1:0] nmi_value;
        logic [1:0]       status;
    } nmi_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CNT_W-1:0]    cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [LBL_IN_W-1:0] s_label_a = '0;
    logic [LBL_IN_W-1:0] s_label_b = '0;
    logic                s_last_point = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CNT_W-1:0]    m_nmi_value;
    logic [1:0]          m_status;

    normalized_mutual_information_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_label_a    (s_label_a),
        .s_label_b    (s_label_b),
        .s_last_point (s_last_point),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_nmi_value  (m_nmi_value),
        .m_status     (m_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    int unsigned   total_pts;
    int unsigned   hist_a [LABELS];
    int unsigned   hist_b [LABELS];
    int unsigned   hist_ab [LABELS*LABELS];
    int unsigned   seen_pts;
    nmi_result_t   pending_nmi [$];

    int            mismatches = 0;
    int            points_sent = 0;
    bit            hold_off = 1'b0;
    int            idle_cycles = 0;

    function automatic longint log2_q16(int unsigned x);
        int unsigned    e;
        int unsigned    t;
        int unsigned    frac;
        longint unsigned y;
        e = 0;
        frac = 0;
        x = x & 32'h1FFFF;
        if (x == 0) return 0;
        t = x;
        while (t > 1) begin
            t = t >> 1;
            e++;
        end
        y = longint'(x) << (31 - e);
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd1 << 32)) begin
                frac = frac | 1;
                y = y >> 1;
            end
        end
        return longint'((e << 16) | frac);
    endfunction

    function automatic int unsigned sat17(int unsigned v);
        return (v < 131071) ? v + 1 : 131071;
    endfunction

    function automatic void clear_hists();
        for (int i = 0; i < LABELS; i++) begin
            hist_a[i] = 0;
            hist_b[i] = 0;
        end
        for (int i = 0; i < LABELS*LABELS; i++) hist_ab[i] = 0;
        seen_pts = 0;
    endfunction

    function automatic void score_point(int unsigned a, int unsigned b, bit last);
        nmi_result_t r;
        longint      ln;
        longint      num;
        longint      den;
        longint unsigned q;
        int unsigned c;
        num = 0;
        den = 0;
        hist_a[a] = sat17(hist_a[a]);
        hist_b[b] = sat17(hist_b[b]);
        hist_ab[a*LABELS+b] = sat17(hist_ab[a*LABELS+b]);
        seen_pts = sat17(seen_pts);
        if (!last) return;
        if (seen_pts > total_pts || seen_pts > 65536 || seen_pts >= 131071) begin
            r.nmi_value = '0;
            r.status = STAT_OVER;
        end else begin
            ln = log2_q16(total_pts);
            for (int i = 0; i < LABELS; i++) begin
                if (hist_a[i] != 0) den += longint'(hist_a[i]) * (ln - log2_q16(hist_a[i]));
                if (hist_b[i] != 0) den += longint'(hist_b[i]) * (ln - log2_q16(hist_b[i]));
            end
            for (int i = 0; i < LABELS; i++) begin
                for (int j = 0; j < LABELS; j++) begin
                    c = hist_ab[i*LABELS+j];
                    if (c != 0)
                        num += longint'(c) * (log2_q16(c) - log2_q16(hist_a[i])
                                              - log2_q16(hist_b[j]) + ln);
                end
            end
            if (den <= 0) begin
                r.nmi_value = '0;
                r.status = STAT_ZERO;
            end else begin
                if (num < 0) num = 0;
                q = (longint'(num) << 17) / longint'(den);
                if (q > 65536) q = 65536;
                r.nmi_value = q[CNT_W-1:0];
                r.status = STAT_OK;
            end
        end
        pending_nmi.push_back(r);
        clear_hists();
    endfunction

    task automatic send_point(int unsigned a, int unsigned b, bit last);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        repeat (gap) @(negedge aclk) s_valid <= 1'b0;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_label_a <= a[LBL_IN_W-1:0];
        s_label_b <= b[LBL_IN_W-1:0];
        s_last_point <= last;
        do @(posedge aclk); while (!s_ready);
        score_point(a, b, last);
        points_sent++;
    endtask

    task automatic drain();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_nmi.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_total(int unsigned v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[CNT_W-1:0];
        total_pts = v & 32'h1FFFF;
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // one subset with labels mostly drawn from the given alphabets (one point in sixteen from all 64 labels)
    task automatic send_subset(int n, int na, int nb, bit tied);
        int unsigned a;
        int unsigned b;
        for (int k = 0; k < n; k++) begin
            a = $urandom_range(0, na - 1);
            b = tied ? (a * 7 + 3) % nb : $urandom_range(0, nb - 1);
            if ($urandom_range(0, 15) == 0) begin
                a = $urandom_range(0, 63);
                b = $urandom_range(0, 63);
            end
            send_point(a, b, k == n - 1);
        end
    endtask

    task automatic test_reset_total();
        send_subset(12, 4, 4, 1'b0);
        send_point(63, 0, 1'b1);
        send_point(0, 63, 1'b0);
        send_point(63, 63, 1'b1);
        drain();
    endtask

    task automatic test_zero_entropy();
        set_total(1);
        send_point(5, 9, 1'b1);
        drain();
        set_total(3);
        send_point(2, 2, 1'b0);
        send_point(2, 2, 1'b0);
        send_point(2, 2, 1'b1);
        drain();
    endtask

    task automatic test_oversize();
        set_total(1);
        send_point(0, 0, 1'b0);
        send_point(1, 1, 1'b1);
        drain();
        set_total(0);
        send_point(42, 21, 1'b1);
        drain();
    endtask

    task automatic test_full_agreement();
        set_total(8);
        for (int k = 0; k < 8; k++) send_point(k, 63 - k, k == 7);
        send_point(10, 20, 1'b0);
        send_point(11, 20, 1'b1);
        drain();
        set_total(65536);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        send_subset(20, 8, 8, 1'b1);
        send_subset(20, 8, 8, 1'b0);
        send_subset(5, 3, 3, 1'b0);
        drain();
        hold_off = 1'b0;
    endtask

    task automatic test_random();
        int n;
        while (points_sent < 1750) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_total($urandom_range(1, 65536));
                    1: set_total($urandom_range(1, 80));
                    2: set_total(65536);
                    default: set_total($urandom_range(0, 131071));
                endcase
            end
            for (int s = 0; s < 3; s++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 50);
                send_subset(n, $urandom_range(1, 64), $urandom_range(1, 64),
                            $urandom_range(0, 1));
            end
            drain();
        end
    endtask

    // result checker
    initial begin
        nmi_result_t exp_r;
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_off && $urandom_range(0, 1) == 0) gap = LONG_HOLD;
            else gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            repeat (gap) @(negedge aclk) m_ready <= 1'b0;
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_nmi.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction nmi=%0d status=%0d",
                             m_nmi_value, m_status);
            end else begin
                exp_r = pending_nmi.pop_front();
                if (m_nmi_value !== exp_r.nmi_value || m_status !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected nmi=%0d status=%0d, got nmi=%0d status=%0d",
                                 exp_r.nmi_value, exp_r.status, m_nmi_value, m_status);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        total_pts = 65536;
        clear_hists();
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_reset_total();
        test_zero_entropy();
        test_oversize();
        test_full_agreement();
        test_backpressure();
        test_random();
        if (mismatches == 0 && pending_nmi.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
